[sv/wrmc_pkg.sv]
`timescale 1ns / 1ps

package wrmc_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned SCORE_BITS_DEF  = 16;

  localparam int unsigned CAT_W   = 2;
  localparam int unsigned COUNT_W = 11;

  // wildcard codes per category
  localparam logic [CAT_W-1:0] LANG_ANY   = 2'd3;
  localparam logic [CAT_W-1:0] PART_ANY   = 2'd2;
  localparam logic [CAT_W-1:0] CAREER_ANY = 2'd2;
  localparam logic [CAT_W-1:0] FOOD_ANY   = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN,
    ST_DRAIN,
    ST_POST
  } wrmc_state_e;

  typedef struct packed {
    logic load_item;
    logic wr_rec;
    logic issue_rd;
    logic load_out;
  } wrmc_cmd_t;

  typedef struct packed {
    logic addr_done;
    logic out_busy;
  } wrmc_sts_t;

endpackage

[sv/wrmc_ctrl.sv]
`timescale 1ns / 1ps

module wrmc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                cmd_i,
  output logic                in_ready_o,
  input  wrmc_pkg::wrmc_sts_t sts_i,
  output wrmc_pkg::wrmc_cmd_t cmd_o
);

  wrmc_pkg::wrmc_state_e state_q, state_d;
  logic                  accept;

  assign accept = in_valid_i && (state_q == wrmc_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wrmc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      wrmc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (cmd_i == wrmc_pkg::CMD_QUERY) ? wrmc_pkg::ST_SCAN : wrmc_pkg::ST_INSERT;
        end
      end
      wrmc_pkg::ST_INSERT: state_d = wrmc_pkg::ST_POST;
      wrmc_pkg::ST_SCAN: begin
        if (sts_i.addr_done) begin
          state_d = wrmc_pkg::ST_DRAIN;
        end
      end
      wrmc_pkg::ST_DRAIN: state_d = wrmc_pkg::ST_POST;
      wrmc_pkg::ST_POST: begin
        if (!sts_i.out_busy) begin
          state_d = wrmc_pkg::ST_IDLE;
        end
      end
      default: state_d = wrmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.load_item = accept;
    case (state_q)
      wrmc_pkg::ST_IDLE:   in_ready_o     = 1'b1;
      wrmc_pkg::ST_INSERT: cmd_o.wr_rec   = 1'b1;
      wrmc_pkg::ST_SCAN:   cmd_o.issue_rd = !sts_i.addr_done;
      wrmc_pkg::ST_DRAIN:  ;
      wrmc_pkg::ST_POST:   cmd_o.load_out = !sts_i.out_busy;
      default:             ;
    endcase
  end

endmodule

[sv/wrmc_dp.sv]
`timescale 1ns / 1ps

module wrmc_dp #(
  parameter int unsigned TABLE_DEPTH = wrmc_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned SCORE_BITS  = wrmc_pkg::SCORE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_i,
  input  logic [wrmc_pkg::CAT_W-1:0]         lang_i,
  input  logic [wrmc_pkg::CAT_W-1:0]         part_i,
  input  logic [wrmc_pkg::CAT_W-1:0]         career_i,
  input  logic [wrmc_pkg::CAT_W-1:0]         food_i,
  input  logic [SCORE_BITS-1:0]              score_i,
  input  wrmc_pkg::wrmc_cmd_t                cmd_in_i,
  output wrmc_pkg::wrmc_sts_t                sts_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [wrmc_pkg::COUNT_W-1:0]       count_o,
  output logic                               dropped_o
);

  localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned REC_W  = 4 * wrmc_pkg::CAT_W + SCORE_BITS;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  logic [REC_W-1:0] rec_mem [TABLE_DEPTH];

  // latched item
  logic                       cmd_q;
  logic [wrmc_pkg::CAT_W-1:0] lang_q, part_q, career_q, food_q;
  logic [SCORE_BITS-1:0]      score_q;

  logic [CNT_W-1:0] rec_cnt_q, rec_cnt_d;
  logic [CNT_W-1:0] scan_addr_q, scan_addr_d;
  logic [CNT_W-1:0] match_q, match_d;
  logic [REC_W-1:0] rd_data_q;
  logic             rd_vld_q;
  logic             drop_q, drop_d;
  logic             full;
  logic             wr_en;
  logic             hit;
  logic             out_valid_q;
  logic [wrmc_pkg::COUNT_W-1:0] count_q;
  logic             dropped_q;

  logic [wrmc_pkg::CAT_W-1:0] r_lang, r_part, r_career, r_food;
  logic [SCORE_BITS-1:0]      r_score;

  assign full  = (rec_cnt_q == DEPTH_C);
  assign wr_en = cmd_in_i.wr_rec && !full;

  assign {r_lang, r_part, r_career, r_food, r_score} = rd_data_q;

  assign hit = (lang_q == wrmc_pkg::LANG_ANY || lang_q == r_lang) &&
               (part_q == wrmc_pkg::PART_ANY || part_q == r_part) &&
               (career_q == wrmc_pkg::CAREER_ANY || career_q == r_career) &&
               (food_q == wrmc_pkg::FOOD_ANY || food_q == r_food) &&
               (r_score >= score_q);

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.load_item) begin
      cmd_q    <= cmd_i;
      lang_q   <= lang_i;
      part_q   <= part_i;
      career_q <= career_i;
      food_q   <= food_i;
      score_q  <= score_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rec_mem[rec_cnt_q[ADDR_W-1:0]] <= {lang_q, part_q, career_q, food_q, score_q};
    end
    if (cmd_in_i.issue_rd) begin
      rd_data_q <= rec_mem[scan_addr_q[ADDR_W-1:0]];
    end
  end

  always_comb begin
    rec_cnt_d   = rec_cnt_q;
    scan_addr_d = scan_addr_q;
    match_d     = match_q;
    drop_d      = drop_q;
    if (cmd_in_i.load_item) begin
      scan_addr_d = '0;
      match_d     = '0;
      drop_d      = 1'b0;
    end
    if (cmd_in_i.wr_rec) begin
      drop_d = full;
    end
    if (wr_en) begin
      rec_cnt_d = rec_cnt_q + CNT_W'(1);
    end
    if (cmd_in_i.issue_rd) begin
      scan_addr_d = scan_addr_q + CNT_W'(1);
    end
    if (rd_vld_q && hit) begin
      match_d = match_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_cnt_q   <= '0;
      scan_addr_q <= '0;
      match_q     <= '0;
      drop_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rec_cnt_q   <= rec_cnt_d;
      scan_addr_q <= scan_addr_d;
      match_q     <= match_d;
      drop_q      <= drop_d;
      rd_vld_q    <= cmd_in_i.issue_rd;
      if (cmd_in_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // count is masked to the port width
  always_ff @(posedge clk_i) begin
    if (cmd_in_i.load_out) begin
      count_q   <= (cmd_q == wrmc_pkg::CMD_QUERY) ? wrmc_pkg::COUNT_W'(match_q)
                                                  : wrmc_pkg::COUNT_W'(rec_cnt_q);
      dropped_q <= (cmd_q == wrmc_pkg::CMD_INSERT) && drop_q;
    end
  end

  assign sts_o.addr_done = (scan_addr_q == rec_cnt_q);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;
  assign dropped_o   = dropped_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_cnt_q <= DEPTH_C)
    else $error("record count exceeds table depth");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_in_i.issue_rd |-> (scan_addr_q < rec_cnt_q))
    else $error("scan read beyond stored records");

  a_no_wr_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_in_i.issue_rd |-> !cmd_in_i.wr_rec)
    else $error("table written during a scan");

  a_match_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_q <= scan_addr_q)
    else $error("match count exceeds records scanned");

endmodule

[sv/wildcard_record_match_count_core.sv]
`timescale 1ns / 1ps

// Wildcard record match counter.
// Input channel (in_valid_i / in_ready_o) carries one item: cmd_i = 0 appends
// a record {lang, part, career, food, score}; cmd_i = 1 counts stored records
// that agree with the query categories (wildcard codes agree with anything)
// and whose score is at least score_i. Output channel (out_valid_o /
// out_ready_i) returns one result per item: count_o (records held after an
// insert, or the match count) and dropped_o (insert found the table full).
// One item is handled at a time; in_ready_o is high only while idle.
// Insert: the record is written in INSERT and the result is loaded into the
// output register in POST; the next item is accepted back in IDLE. Query:
// the table RAM is read one record per cycle over its single read port in
// SCAN, then DRAIN and POST follow; longer tables make longer queries.
// Reset empties the table (record count to zero); no clearing pass is needed.
// A result waits in the output register; if the receiver stalls, the block
// finishes the next item and holds it until the output register is free.

module wildcard_record_match_count_core #(
  parameter int unsigned TABLE_DEPTH = wrmc_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned SCORE_BITS  = wrmc_pkg::SCORE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cmd_i,
  input  logic [wrmc_pkg::CAT_W-1:0]   lang_i,
  input  logic [wrmc_pkg::CAT_W-1:0]   part_i,
  input  logic [wrmc_pkg::CAT_W-1:0]   career_i,
  input  logic [wrmc_pkg::CAT_W-1:0]   food_i,
  input  logic [SCORE_BITS-1:0]        score_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [wrmc_pkg::COUNT_W-1:0] count_o,
  output logic                         dropped_o
);

  wrmc_pkg::wrmc_cmd_t ctl_cmd;
  wrmc_pkg::wrmc_sts_t dp_sts;

  wrmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctl_cmd)
  );

  wrmc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SCORE_BITS  (SCORE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .lang_i      (lang_i),
    .part_i      (part_i),
    .career_i    (career_i),
    .food_i      (food_i),
    .score_i     (score_i),
    .cmd_in_i    (ctl_cmd),
    .sts_o       (dp_sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .count_o     (count_o),
    .dropped_o   (dropped_o)
  );

endmodule

[dv/wildcard_record_match_count_core_tb.sv]
`timescale 1ns / 1ps

module wildcard_record_match_count_core_tb;
  import wrmc_pkg::*;

  localparam int unsigned DEPTH    = TABLE_DEPTH_DEF;
  localparam int unsigned SW       = SCORE_BITS_DEF;
  localparam int unsigned IDLE_PCT = 28;
  localparam int unsigned CALM_LO  = 300;
  localparam int unsigned CALM_HI  = 420;
  localparam int unsigned N_RANDOM = 554;
  localparam int unsigned MAX_MSGS = 40;

  localparam logic [CAT_W-1:0] LANG_CPP      = 2'd0;
  localparam logic [CAT_W-1:0] LANG_JAVA     = 2'd1;
  localparam logic [CAT_W-1:0] LANG_PYTHON   = 2'd2;
  localparam logic [CAT_W-1:0] PART_BACKEND  = 2'd0;
  localparam logic [CAT_W-1:0] PART_FRONTEND = 2'd1;
  localparam logic [CAT_W-1:0] PART_UNUSED   = 2'd3;
  localparam logic [CAT_W-1:0] CAREER_JUNIOR = 2'd0;
  localparam logic [CAT_W-1:0] CAREER_SENIOR = 2'd1;
  localparam logic [CAT_W-1:0] CAREER_UNUSED = 2'd3;
  localparam logic [CAT_W-1:0] FOOD_CHICKEN  = 2'd0;
  localparam logic [CAT_W-1:0] FOOD_PIZZA    = 2'd1;
  localparam logic [CAT_W-1:0] FOOD_UNUSED   = 2'd3;
  localparam logic [SW-1:0]    SCORE_MAX     = '1;
  localparam logic [SW-1:0]    SCORE_MID     = 16'h8000;

  typedef struct packed {
    logic             cmd;
    logic [CAT_W-1:0] lang;
    logic [CAT_W-1:0] part;
    logic [CAT_W-1:0] career;
    logic [CAT_W-1:0] food;
    logic [SW-1:0]    score;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               dropped;
  } result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  logic               out_valid;
  logic               out_ready;
  logic [COUNT_W-1:0] count;
  logic               dropped;
  item_t              in_item;
  logic               in_took;

  item_t       item_queue[$];
  result_t     want_results[$];
  item_t       held_recs[DEPTH];
  int unsigned held_n = 0;
  int unsigned accepted_n = 0;
  int unsigned returned_n = 0;
  int unsigned total_n;
  int unsigned err_cnt = 0;
  result_t     got_r;
  result_t     want_r;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  wildcard_record_match_count_core #(
    .TABLE_DEPTH(DEPTH),
    .SCORE_BITS (SW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .cmd_i      (in_item.cmd),
    .lang_i     (in_item.lang),
    .part_i     (in_item.part),
    .career_i   (in_item.career),
    .food_i     (in_item.food),
    .score_i    (in_item.score),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .count_o    (count),
    .dropped_o  (dropped)
  );

  // Updates the mirrored table and returns what the block should answer.
  function automatic result_t tally_item(item_t it);
    result_t     r;
    int unsigned hits;
    r    = '0;
    hits = 0;
    if (it.cmd == CMD_INSERT) begin
      if (held_n < DEPTH) begin
        held_recs[held_n] = it;
        held_n++;
      end else begin
        r.dropped = 1'b1;
      end
      hits = held_n;
    end else begin
      for (int unsigned i = 0; i < held_n; i++) begin
        if ((it.lang == LANG_ANY || it.lang == held_recs[i].lang) &&
            (it.part == PART_ANY || it.part == held_recs[i].part) &&
            (it.career == CAREER_ANY || it.career == held_recs[i].career) &&
            (it.food == FOOD_ANY || it.food == held_recs[i].food) &&
            held_recs[i].score >= it.score)
          hits++;
      end
    end
    r.count = COUNT_W'(hits);
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    err_cnt++;
    if (err_cnt <= MAX_MSGS)
      $display("%0t: result %0d %s: got %0d, want %0d", $time, returned_n, what, got, want);
  endtask

  task automatic push_item(logic cmd, logic [CAT_W-1:0] lang, logic [CAT_W-1:0] part,
                           logic [CAT_W-1:0] career, logic [CAT_W-1:0] food,
                           logic [SW-1:0] score);
    item_t it;
    it = '{cmd, lang, part, career, food, score};
    item_queue.push_back(it);
  endtask

  // Stored categories lean on the real codes but keep wildcard and unused ones.
  function automatic logic [CAT_W-1:0] rec_cat();
    if ($urandom_range(0, 3) == 0) return CAT_W'($urandom_range(0, 3));
    return CAT_W'($urandom_range(0, 1));
  endfunction

  function automatic logic [CAT_W-1:0] query_cat(logic [CAT_W-1:0] wild);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return wild;
    if (r < 8) return CAT_W'($urandom_range(0, 1));
    return CAT_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [SW-1:0] rand_score();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return SCORE_MAX;
      2:       return SW'($urandom_range(0, 15));
      default: return SW'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_random_insert();
    push_item(CMD_INSERT, rec_cat(), rec_cat(), rec_cat(), rec_cat(),
              SW'($urandom_range(0, 65535)));
  endtask

  task automatic push_random_query();
    push_item(CMD_QUERY, query_cat(LANG_ANY), query_cat(PART_ANY), query_cat(CAREER_ANY),
              query_cat(FOOD_ANY), rand_score());
  endtask

  function automatic bit idle_roll(int unsigned n);
    if (n >= CALM_LO && n < CALM_HI) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // Input side: valid holds with the same payload until the transfer.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else if (!in_valid || in_took) begin
      if (item_queue.size() != 0 && !idle_roll(accepted_n)) begin
        in_item  <= item_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) out_ready <= 1'b0;
    else out_ready <= !idle_roll(returned_n);
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        want_results.push_back(tally_item(in_item));
        accepted_n++;
      end
      if (out_valid && out_ready) begin
        got_r = '{count, dropped};
        if (want_results.size() == 0) begin
          report_mismatch("arrived with nothing pending", got_r.count, 0);
        end else begin
          want_r = want_results.pop_front();
          if (got_r.count !== want_r.count)
            report_mismatch("count", got_r.count, want_r.count);
          if (got_r.dropped !== want_r.dropped)
            report_mismatch("dropped", got_r.dropped, want_r.dropped);
        end
        returned_n++;
      end
    end
  end

  initial begin
    int unsigned k;
    rst_ni = 1'b0;

    // empty table
    push_item(CMD_QUERY, LANG_ANY, PART_ANY, CAREER_ANY, FOOD_ANY, '0);
    push_item(CMD_QUERY, LANG_CPP, PART_BACKEND, CAREER_JUNIOR, FOOD_CHICKEN, SCORE_MAX);
    push_item(CMD_INSERT, LANG_CPP, PART_BACKEND, CAREER_JUNIOR, FOOD_CHICKEN, '0);
    push_item(CMD_INSERT, LANG_JAVA, PART_FRONTEND, CAREER_SENIOR, FOOD_PIZZA, SCORE_MAX);
    push_item(CMD_INSERT, LANG_PYTHON, PART_BACKEND, CAREER_SENIOR, FOOD_CHICKEN, SCORE_MID);
    // stored wildcards only agree with a wildcard in the query
    push_item(CMD_INSERT, LANG_ANY, PART_ANY, CAREER_ANY, FOOD_ANY, 16'd100);
    push_item(CMD_INSERT, LANG_CPP, PART_UNUSED, CAREER_UNUSED, FOOD_UNUSED, 16'h7fff);
    push_item(CMD_INSERT, LANG_JAVA, PART_FRONTEND, CAREER_SENIOR, FOOD_PIZZA, SCORE_MAX);
    push_item(CMD_QUERY, LANG_ANY, PART_ANY, CAREER_ANY, FOOD_ANY, '0);
    push_item(CMD_QUERY, LANG_ANY, PART_ANY, CAREER_ANY, FOOD_ANY, SCORE_MAX);
    push_item(CMD_QUERY, LANG_JAVA, PART_FRONTEND, CAREER_SENIOR, FOOD_PIZZA, '0);
    push_item(CMD_QUERY, LANG_ANY, PART_ANY, CAREER_ANY, FOOD_ANY, SCORE_MID);
    push_item(CMD_QUERY, LANG_CPP, PART_ANY, CAREER_ANY, FOOD_ANY, '0);
    push_item(CMD_QUERY, LANG_ANY, PART_UNUSED, CAREER_ANY, FOOD_ANY, '0);
    push_item(CMD_QUERY, LANG_ANY, PART_ANY, CAREER_UNUSED, FOOD_UNUSED, 16'h7fff);
    push_item(CMD_QUERY, LANG_PYTHON, PART_BACKEND, CAREER_SENIOR, FOOD_CHICKEN,
              SCORE_MID + 16'd1);
    push_item(CMD_QUERY, LANG_PYTHON, PART_BACKEND, CAREER_SENIOR, FOOD_CHICKEN, SCORE_MID);

    for (k = 0; k < N_RANDOM; k++) begin
      if ($urandom_range(0, 99) < 55) push_random_insert();
      else push_random_query();
    end

    // wide scans over the grown table
    push_item(CMD_INSERT, LANG_CPP, PART_BACKEND, CAREER_JUNIOR, FOOD_CHICKEN, '0);
    push_item(CMD_QUERY, LANG_ANY, PART_ANY, CAREER_ANY, FOOD_ANY, '0);
    push_item(CMD_INSERT, LANG_ANY, PART_UNUSED, CAREER_UNUSED, FOOD_UNUSED, SCORE_MAX);
    push_item(CMD_QUERY, LANG_ANY, PART_ANY, CAREER_ANY, FOOD_ANY, SCORE_MAX);
    for (k = 0; k < 4; k++) push_random_query();
    push_random_insert();
    total_n = item_queue.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_n == total_n && want_results.size() == 0);
    repeat (40) @(posedge clk_i);
    if (want_results.size() != 0)
      report_mismatch("results never returned", want_results.size(), 0);
    if (err_cnt == 0) begin
      $display("wildcard_record_match_count_core_tb: PASS");
    end else begin
      $display("wildcard_record_match_count_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("wildcard_record_match_count_core_tb: FAIL");
    $finish;
  end

endmodule

[files.f]
sv/wrmc_pkg.sv
sv/wrmc_ctrl.sv
sv/wrmc_dp.sv
sv/wildcard_record_match_count_core.sv
dv/wildcard_record_match_count_core_tb.sv
